// ----- hdl/mixsc_pkg.sv -----
// Shared types, register indexes and defaults for the two-source mixer with soft clip.
package mixsc_pkg;

  // Payload and register field types.
  typedef logic signed [15:0] sample_t;
  typedef logic        [15:0] gain_t;
  typedef logic        [14:0] ratio_t;
  typedef logic        [2:0]  cfg_idx_t;
  typedef logic        [15:0] cfg_data_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_PHONE_VOLUME    = 3'd0,
    REG_MIC_VOLUME      = 3'd1,
    REG_PHONE_MIX_RATIO = 3'd2,
    REG_PHONE_MUTE      = 3'd3,
    REG_MIC_MUTE        = 3'd4
  } cfg_reg_t;

  // Reset values and range limits of the registers.
  localparam gain_t  GAIN_RESET  = 16'd16384;
  localparam gain_t  GAIN_MAX    = 16'd32768;
  localparam ratio_t RATIO_RESET = 15'd16384;
  localparam ratio_t RATIO_MAX   = 15'd16384;

  // Default resolution of the soft-clip curve, in table steps per 1.0.
  localparam int unsigned CLIP_STEPS_DEFAULT = 64;

endpackage

// ----- hdl/mixsc_ifs.sv -----
// Channel interfaces of the mixer: input slot, mixed result and register writes.
interface mixsc_in_if;
  import mixsc_pkg::*;

  logic    valid;
  logic    ready;
  sample_t phone_sample;
  logic    phone_valid;
  sample_t mic_sample;
  logic    mic_valid;

  modport source (output valid, output phone_sample, output phone_valid,
                  output mic_sample, output mic_valid, input ready);
  modport sink   (input valid, input phone_sample, input phone_valid,
                  input mic_sample, input mic_valid, output ready);
endinterface

interface mixsc_out_if;
  import mixsc_pkg::*;

  logic    valid;
  logic    ready;
  sample_t mixed_sample;

  modport source (output valid, output mixed_sample, input ready);
  modport sink   (input valid, input mixed_sample, output ready);
endinterface

interface mixsc_cfg_if;
  import mixsc_pkg::*;

  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hdl/two_source_gain_mixer_soft_clip.sv -----
// Top level of the two-source gain mixer with soft clipping.
// The mixer takes one beat per clock unless an output stall backs up to the input.
// Stage one scales each source by its gain, stage two applies the phone mix ratio,
// stage three adds the two terms and forms the clip-table index, and stage four
// reads the clip table, saturates and holds the result in the output register. No
// stage chains two multipliers, and a stall on the output holds each full stage up
// to the first empty one. A beat with neither source flag set gives no result.
// Register writes are taken in any cycle; the gains are read as a beat is accepted
// and the mix ratio as it enters stage two, so write the registers only while no
// beat is in flight. The clip table has 3*CLIP_STEPS_PER_UNIT+1 constant entries
// worked out at elaboration; no initialization pass is needed.
module two_source_gain_mixer_soft_clip #(
  parameter int unsigned CLIP_STEPS_PER_UNIT = mixsc_pkg::CLIP_STEPS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst_n,
  mixsc_in_if.sink           in_ch,
  mixsc_out_if.source        out_ch,
  mixsc_cfg_if.sink          cfg_ch
);
  import mixsc_pkg::*;

  // Clip table geometry.
  localparam int unsigned ROM_DEPTH = 3 * CLIP_STEPS_PER_UNIT + 1;
  localparam int unsigned IDX_MAX   = 3 * CLIP_STEPS_PER_UNIT;
  localparam int unsigned IDX_W     = $clog2(ROM_DEPTH);
  localparam int unsigned SW        = $clog2(CLIP_STEPS_PER_UNIT + 1);
  localparam int unsigned PROD_W    = 17 + SW;
  localparam int unsigned RAW_W     = PROD_W - 15;

  // exp(-1/S) in Q30 as an eight-term alternating Taylor sum.
  localparam longint unsigned Q30_ONE = 64'd1 << 30;
  localparam longint unsigned SL = longint'(CLIP_STEPS_PER_UNIT);
  localparam longint unsigned T1 = Q30_ONE / (SL * 1);
  localparam longint unsigned T2 = T1 / (SL * 2);
  localparam longint unsigned T3 = T2 / (SL * 3);
  localparam longint unsigned T4 = T3 / (SL * 4);
  localparam longint unsigned T5 = T4 / (SL * 5);
  localparam longint unsigned T6 = T5 / (SL * 6);
  localparam longint unsigned T7 = T6 / (SL * 7);
  localparam longint unsigned D_Q30 = Q30_ONE - T1 + T2 - T3 + T4 - T5 + T6 - T7;

  // One table entry: 1 - d^n, rounded to Q15, with d^n built by truncating products.
  function automatic logic [14:0] clip_entry(longint unsigned d, int unsigned n);
    longint unsigned p;
    longint unsigned r;
    p = 64'd1 << 30;
    for (int unsigned j = 0; j < n; j++) begin
      p = (p * d) >> 30;
    end
    r = 64'd32768 - ((p + (64'd1 << 14)) >> 15);
    return 15'(r);
  endfunction

  // Constant clip table.
  logic [14:0] clip_rom [ROM_DEPTH];
  for (genvar k = 0; k < ROM_DEPTH; k++) begin : g_rom
    localparam logic [14:0] ENTRY = clip_entry(D_Q30, CLIP_STEPS_PER_UNIT + k);
    assign clip_rom[k] = ENTRY;
  end

  // Configuration registers.
  gain_t  phone_volume_r;
  gain_t  mic_volume_r;
  ratio_t phone_mix_ratio_r;
  logic   phone_mute_r;
  logic   mic_mute_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phone_volume_r    <= GAIN_RESET;
      mic_volume_r      <= GAIN_RESET;
      phone_mix_ratio_r <= RATIO_RESET;
      phone_mute_r      <= 1'b0;
      mic_mute_r        <= 1'b0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_PHONE_VOLUME:    phone_volume_r    <= cfg_ch.data;
        REG_MIC_VOLUME:      mic_volume_r      <= cfg_ch.data;
        REG_PHONE_MIX_RATIO: phone_mix_ratio_r <= cfg_ch.data[14:0];
        REG_PHONE_MUTE:      phone_mute_r      <= cfg_ch.data[0];
        REG_MIC_MUTE:        mic_mute_r        <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  // Effective gains: limited to 2.0 (ratio to 1.0) and forced to zero by mute.
  gain_t  phone_gain;
  gain_t  mic_gain;
  ratio_t mix_ratio;

  assign phone_gain = phone_mute_r ? '0 :
                      ((phone_volume_r > GAIN_MAX) ? GAIN_MAX : phone_volume_r);
  assign mic_gain   = mic_mute_r ? '0 :
                      ((mic_volume_r > GAIN_MAX) ? GAIN_MAX : mic_volume_r);
  assign mix_ratio  = (phone_mix_ratio_r > RATIO_MAX) ? RATIO_MAX : phone_mix_ratio_r;

  // Pipeline valid bits and per-stage advance enables.
  logic v1_r, v2_r, v3_r, out_valid_r;
  logic en1, en2, en3, en4;

  assign en4 = !out_valid_r || out_ch.ready;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_ch.ready = en1;

  logic accept;
  assign accept = in_ch.valid && en1;

  // Stage 1: source samples times their gains, floor-shifted back to Q3.15.
  sample_t            ps;
  sample_t            ms;
  logic signed [32:0] pprod;
  logic signed [32:0] mprod;
  logic signed [17:0] p1_nxt, m1_nxt;
  logic signed [17:0] p1_r, m1_r;

  assign ps     = in_ch.phone_valid ? in_ch.phone_sample : '0;
  assign ms     = in_ch.mic_valid ? in_ch.mic_sample : '0;
  assign pprod  = 33'(ps) * 33'($signed({1'b0, phone_gain}));
  assign mprod  = 33'(ms) * 33'($signed({1'b0, mic_gain}));
  assign p1_nxt = 18'(pprod >>> 14);
  assign m1_nxt = 18'(mprod >>> 14);

  // Stage 2: phone term times the mix ratio; mic term rides along.
  logic signed [33:0] rprod;
  logic signed [17:0] p2_nxt;
  logic signed [17:0] p2_r, m2_r;

  assign rprod  = 34'(p1_r) * 34'($signed({1'b0, mix_ratio}));
  assign p2_nxt = 18'(rprod >>> 14);

  // Stage 3: sum, magnitude and clip-table index.
  logic signed [18:0] x_sum;
  logic        [17:0] mag;
  logic        [16:0] diff;
  logic [PROD_W-1:0]  idx_prod;
  logic [RAW_W-1:0]   idx_raw;
  logic [IDX_W-1:0]   idx_nxt;
  logic               pass_nxt;

  assign x_sum    = 19'(p2_r) + 19'(m2_r);
  assign mag      = x_sum[18] ? 18'(-x_sum) : 18'(x_sum);
  assign pass_nxt = (mag <= 18'd32768);
  assign diff     = 17'(mag - 18'd32768);
  assign idx_prod = PROD_W'(diff) * PROD_W'(CLIP_STEPS_PER_UNIT);
  assign idx_raw  = RAW_W'(idx_prod >> 15);
  assign idx_nxt  = (idx_raw > RAW_W'(IDX_MAX)) ? IDX_W'(IDX_MAX) : IDX_W'(idx_raw);

  logic [IDX_W-1:0] idx3_r;
  logic             pass3_r;
  logic             neg3_r;
  logic             top3_r;
  sample_t          x3_r;

  // Stage 4: pass-through or table value with sign, then saturation.
  logic [14:0] rom_val;
  sample_t     y_nxt;
  sample_t     y_r;

  assign rom_val = clip_rom[idx3_r];

  always_comb begin
    if (pass3_r) begin
      y_nxt = top3_r ? 16'sh7FFF : x3_r;
    end else if (neg3_r) begin
      y_nxt = -$signed({1'b0, rom_val});
    end else begin
      y_nxt = $signed({1'b0, rom_val});
    end
  end

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1) v1_r <= accept && (in_ch.phone_valid || in_ch.mic_valid);
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) out_valid_r <= v3_r;
    end
  end

  // Pipeline payload registers.
  always_ff @(posedge clk) begin
    if (en1) begin
      p1_r <= p1_nxt;
      m1_r <= m1_nxt;
    end
    if (en2) begin
      p2_r <= p2_nxt;
      m2_r <= m1_r;
    end
    if (en3) begin
      idx3_r  <= idx_nxt;
      pass3_r <= pass_nxt;
      neg3_r  <= x_sum[18];
      top3_r  <= (x_sum == 19'sd32768);
      x3_r    <= x_sum[15:0];
    end
    if (en4) begin
      y_r <= y_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.mixed_sample = y_r;

  // A beat with no source present leaves no item in the pipeline.
  a_drop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !in_ch.phone_valid && !in_ch.mic_valid |=> !v1_r)
    else $error("beat without sources entered the pipeline");

  // A beat with a source present always enters stage one.
  a_keep_present: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_ch.phone_valid || in_ch.mic_valid) |=> v1_r)
    else $error("beat with a source was lost at stage one");

  // A stalled stage three keeps its item and its table index.
  a_stage3_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && !en3 |=> v3_r && $stable(idx3_r) && $stable(pass3_r) && $stable(x3_r))
    else $error("stage three changed while stalled");

  // The table index never runs past the last entry.
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> (idx3_r <= IDX_W'(IDX_MAX)))
    else $error("clip table index out of range");

endmodule

// ----- tb/two_source_gain_mixer_soft_clip_tb.sv -----
// Self-checking testbench of the two-source gain mixer with soft clipping.
module two_source_gain_mixer_soft_clip_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mixsc_pkg::*;

  localparam int unsigned CLIP_STEPS = CLIP_STEPS_DEFAULT;
  localparam int CURVE_LAST = 3 * CLIP_STEPS;
  localparam int DRAIN_CYCLES = 8;
  localparam int TAIL_CYCLES = 20;
  localparam int PHASES = 13;
  localparam int SLOTS_PER_PHASE = 45;
  localparam cfg_idx_t REG_UNUSED_FIRST = 3'd5;
  localparam cfg_idx_t REG_UNUSED_LAST = 3'd7;
  localparam sample_t S_MIN = 16'sh8000;
  localparam sample_t S_MAX = 16'sh7FFF;
  localparam sample_t S_HALF = 16'sh4000;

  typedef enum {ROW_SLOT, ROW_REG} row_kind_t;
  typedef enum {EXP_PREDICT, EXP_TYPED, EXP_NONE} exp_kind_t;

  typedef struct {
    sample_t phone_sample;
    logic    phone_valid;
    sample_t mic_sample;
    logic    mic_valid;
  } mix_slot_t;

  typedef struct {
    row_kind_t kind;
    cfg_idx_t  reg_idx;
    cfg_data_t reg_data;
    mix_slot_t slot;
    exp_kind_t exp_kind;
    sample_t   exp_sample;
  } mix_row_t;

  logic clk;
  logic rst_n;

  mixsc_in_if  in_if();
  mixsc_out_if out_if();
  mixsc_cfg_if cfg_if();

  two_source_gain_mixer_soft_clip #(
    .CLIP_STEPS_PER_UNIT(CLIP_STEPS)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if),
    .cfg_ch(cfg_if)
  );

  // Shadow copy of the register file and the clip curve.
  int      clip_curve [0:CURVE_LAST];
  gain_t   phone_vol_q;
  gain_t   mic_vol_q;
  ratio_t  ratio_q;
  logic    phone_mute_q;
  logic    mic_mute_q;

  sample_t  mix_expected [$];
  mix_row_t directed_rows [$];
  int       err_count = 0;
  int       results_checked = 0;
  int       slots_sent = 0;
  int       empty_slots = 0;
  int       reg_writes = 0;
  int       settings_used = 0;
  bit       burst = 1'b0;

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Run limit.
  initial begin
    #2000000;
    $display("%0t: run timed out with %0d results outstanding", $time, mix_expected.size());
    $display("== FAIL ==");
    $finish;
  end

  // Wait drawn per beat; in burst phases every draw is zero.
  function automatic int draw_wait();
    return burst ? 0 : $urandom_range(0, 9);
  endfunction

  // The curve holds 1 - exp(-|x|) for |x| from 1.0 to 4.0 in Q1.15.
  function automatic void build_clip_curve();
    longint unsigned term;
    longint          dsum;
    longint unsigned d;
    longint unsigned p;
    term = 64'd1 << 30;
    dsum = longint'(64'd1 << 30);
    for (int n = 1; n < 8; n++) begin
      term = term / (longint'(CLIP_STEPS) * n);
      if (n % 2 == 1) dsum -= longint'(term);
      else dsum += longint'(term);
    end
    d = longint'(dsum);
    p = 64'd1 << 30;
    for (int j = 0; j < CLIP_STEPS; j++) p = (p * d) >> 30;
    for (int j = 0; j <= CURVE_LAST; j++) begin
      clip_curve[j] = 32768 - int'((p + 64'd16384) >> 15);
      p = (p * d) >> 30;
    end
  endfunction

  // Expected mixed sample of one slot under the current register values.
  function automatic sample_t mix_predict(mix_slot_t s);
    longint ps, ms, pg, mg, ratio, pterm, mterm, x, mag, y, idx;
    ps = s.phone_valid ? longint'(s.phone_sample) : 64'sd0;
    ms = s.mic_valid ? longint'(s.mic_sample) : 64'sd0;
    pg = phone_mute_q ? 64'sd0 :
         ((phone_vol_q > GAIN_MAX) ? longint'(GAIN_MAX) : longint'(phone_vol_q));
    mg = mic_mute_q ? 64'sd0 :
         ((mic_vol_q > GAIN_MAX) ? longint'(GAIN_MAX) : longint'(mic_vol_q));
    ratio = (ratio_q > RATIO_MAX) ? longint'(RATIO_MAX) : longint'(ratio_q);
    pterm = (((ps * pg) >>> 14) * ratio) >>> 14;
    mterm = (ms * mg) >>> 14;
    x = pterm + mterm;
    mag = (x < 0) ? -x : x;
    // Magnitudes up to 1.0 pass; beyond that the curve takes over.
    if (mag <= 32768) begin
      y = x;
    end else begin
      idx = ((mag - 32768) * longint'(CLIP_STEPS)) >>> 15;
      if (idx > CURVE_LAST) idx = CURVE_LAST;
      y = (x < 0) ? -longint'(clip_curve[idx]) : longint'(clip_curve[idx]);
    end
    if (y > 32767) y = 32767;
    if (y < -32768) y = -32768;
    return sample_t'(y);
  endfunction

  // Register write as the block decodes it; unknown indexes are dropped.
  function automatic void apply_reg(cfg_idx_t idx, cfg_data_t data);
    case (idx)
      REG_PHONE_VOLUME:    phone_vol_q = data;
      REG_MIC_VOLUME:      mic_vol_q = data;
      REG_PHONE_MIX_RATIO: ratio_q = data[14:0];
      REG_PHONE_MUTE:      phone_mute_q = data[0];
      REG_MIC_MUTE:        mic_mute_q = data[0];
      default: ;
    endcase
  endfunction

  function automatic mix_row_t slot_row(sample_t p, logic pv, sample_t m, logic mv,
                                        exp_kind_t ek, sample_t ev);
    mix_row_t r;
    r.kind = ROW_SLOT;
    r.reg_idx = REG_PHONE_VOLUME;
    r.reg_data = '0;
    r.slot = '{p, pv, m, mv};
    r.exp_kind = ek;
    r.exp_sample = ev;
    return r;
  endfunction

  function automatic mix_row_t reg_row(cfg_idx_t idx, cfg_data_t d);
    mix_row_t r;
    r.kind = ROW_REG;
    r.reg_idx = idx;
    r.reg_data = d;
    r.slot = '{16'sd0, 1'b0, 16'sd0, 1'b0};
    r.exp_kind = EXP_NONE;
    r.exp_sample = 16'sd0;
    return r;
  endfunction

  function automatic sample_t rand_sample();
    case ($urandom_range(0, 7))
      0: return S_MIN;
      1: return S_MAX;
      2: return 16'sd0;
      3: return sample_t'(int'($urandom_range(0, 512)) - 256);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic mix_slot_t rand_slot();
    mix_slot_t s;
    int flags;
    flags = $urandom_range(0, 9);
    s.phone_sample = rand_sample();
    s.mic_sample = rand_sample();
    s.phone_valid = (flags == 0 || flags == 3 || flags == 4) ? 1'b0 : 1'b1;
    s.mic_valid = (flags == 0 || flags == 1 || flags == 2) ? 1'b0 : 1'b1;
    return s;
  endfunction

  // Drive one slot beat and record what it should produce once accepted.
  task automatic send_slot(input mix_slot_t s, input exp_kind_t ek, input sample_t ev);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.phone_sample <= s.phone_sample;
    in_if.phone_valid <= s.phone_valid;
    in_if.mic_sample <= s.mic_sample;
    in_if.mic_valid <= s.mic_valid;
    do @(posedge clk); while (!in_if.ready);
    slots_sent++;
    if (!(s.phone_valid || s.mic_valid)) empty_slots++;
    else if (ek == EXP_TYPED) mix_expected.push_back(ev);
    else if (ek == EXP_PREDICT) mix_expected.push_back(mix_predict(s));
  endtask

  // Drive one register write beat; valid stays high for a following write.
  task automatic write_reg(input cfg_idx_t idx, input cfg_data_t data);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      cfg_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= data;
    do @(posedge clk); while (!cfg_if.ready);
    apply_reg(idx, data);
    reg_writes++;
  endtask

  task automatic finish_regs();
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Hold the sender until every expected result is out and the pipe is empty.
  task automatic wait_mix_drained();
    in_if.valid <= 1'b0;
    while (mix_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register setting of one random phase; the first three are fixed corners.
  task automatic program_setting(input int phase);
    cfg_data_t mute_data;
    case (phase)
      0: begin
        write_reg(REG_PHONE_VOLUME, GAIN_RESET);
        write_reg(REG_MIC_VOLUME, GAIN_RESET);
        write_reg(REG_PHONE_MIX_RATIO, 16'(RATIO_RESET));
        write_reg(REG_PHONE_MUTE, 16'h0000);
        write_reg(REG_MIC_MUTE, 16'h0000);
      end
      1: begin
        write_reg(REG_PHONE_VOLUME, 16'hFFFF);
        write_reg(REG_MIC_VOLUME, GAIN_MAX);
        write_reg(REG_PHONE_MIX_RATIO, 16'hFFFF);
        write_reg(REG_PHONE_MUTE, 16'hFFFE);
        write_reg(REG_MIC_MUTE, 16'hFFFE);
      end
      2: begin
        write_reg(REG_PHONE_VOLUME, 16'h0000);
        write_reg(REG_MIC_VOLUME, 16'hFFFF);
        write_reg(REG_PHONE_MIX_RATIO, 16'h0000);
        write_reg(REG_PHONE_MUTE, 16'h0000);
        write_reg(REG_MIC_MUTE, 16'h0000);
      end
      default: begin
        case ($urandom_range(0, 4))
          0: write_reg(REG_PHONE_VOLUME, GAIN_MAX);
          1: write_reg(REG_PHONE_VOLUME, 16'($urandom));
          default: write_reg(REG_PHONE_VOLUME, 16'($urandom_range(0, 32768)));
        endcase
        case ($urandom_range(0, 4))
          0: write_reg(REG_MIC_VOLUME, 16'h0000);
          1: write_reg(REG_MIC_VOLUME, 16'($urandom));
          default: write_reg(REG_MIC_VOLUME, 16'($urandom_range(0, 32768)));
        endcase
        case ($urandom_range(0, 3))
          0: write_reg(REG_PHONE_MIX_RATIO, 16'($urandom));
          default: write_reg(REG_PHONE_MIX_RATIO, 16'($urandom_range(0, 16384)));
        endcase
        // Upper data bits of the mute registers are don't-care.
        mute_data = 16'($urandom);
        mute_data[0] = ($urandom_range(0, 3) == 0);
        write_reg(REG_PHONE_MUTE, mute_data);
        mute_data = 16'($urandom);
        mute_data[0] = ($urandom_range(0, 3) == 0);
        write_reg(REG_MIC_MUTE, mute_data);
        if ($urandom_range(0, 2) == 0)
          write_reg(cfg_idx_t'($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST)),
                    16'($urandom));
      end
    endcase
    settings_used++;
  endtask

  // Result receiver with a random stall before each beat.
  initial begin
    int stall;
    out_if.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
    end
  end

  // Compare each result beat with the oldest expectation.
  always @(posedge clk) begin
    sample_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (mix_expected.size() == 0) begin
        err_count++;
        $display("%0t: unexpected mixed_sample beat, expected none, actual %0d",
                 $time, out_if.mixed_sample);
      end else begin
        want = mix_expected.pop_front();
        results_checked++;
        if (out_if.mixed_sample !== want) begin
          err_count++;
          $display("%0t: mixed_sample mismatch, expected %0d, actual %0d",
                   $time, want, out_if.mixed_sample);
        end
      end
    end
  end

  // Directed table, then random phases, then the end of run.
  initial begin
    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.phone_sample <= '0;
    in_if.phone_valid <= 1'b0;
    in_if.mic_sample <= '0;
    in_if.mic_valid <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= REG_PHONE_VOLUME;
    cfg_if.data <= '0;
    build_clip_curve();
    phone_vol_q = GAIN_RESET;
    mic_vol_q = GAIN_RESET;
    ratio_q = RATIO_RESET;
    phone_mute_q = 1'b0;
    mic_mute_q = 1'b0;

    // Reset defaults: both sources at unity, so extremes pass straight through.
    directed_rows.push_back(slot_row(16'sd0, 1, 16'sd0, 1, EXP_TYPED, 16'sd0));
    directed_rows.push_back(slot_row(16'sd123, 0, -16'sd77, 0, EXP_NONE, 16'sd0));
    directed_rows.push_back(slot_row(S_MAX, 1, 16'sd0, 0, EXP_TYPED, S_MAX));
    directed_rows.push_back(slot_row(S_MIN, 1, 16'sd0, 0, EXP_TYPED, S_MIN));
    directed_rows.push_back(slot_row(16'sd0, 0, S_MAX, 1, EXP_TYPED, S_MAX));
    directed_rows.push_back(slot_row(16'sd0, 0, S_MIN, 1, EXP_TYPED, S_MIN));
    // A sum of exactly plus one passes the clip and saturates.
    directed_rows.push_back(slot_row(S_HALF, 1, S_HALF, 1, EXP_TYPED, S_MAX));
    directed_rows.push_back(slot_row(-S_HALF, 1, -S_HALF, 1, EXP_TYPED, S_MIN));
    directed_rows.push_back(slot_row(S_MAX, 1, S_MAX, 1, EXP_PREDICT, 16'sd0));
    directed_rows.push_back(slot_row(S_MIN, 1, S_MIN, 1, EXP_PREDICT, 16'sd0));
    // A sample whose flag is clear counts as zero.
    directed_rows.push_back(slot_row(16'sd100, 0, -16'sd200, 1, EXP_TYPED, -16'sd200));
    // Gains above range act as 2.0; full negative sum hits the end of the curve.
    directed_rows.push_back(reg_row(REG_PHONE_VOLUME, 16'hFFFF));
    directed_rows.push_back(reg_row(REG_MIC_VOLUME, 16'd40000));
    directed_rows.push_back(slot_row(S_MIN, 1, S_MIN, 1, EXP_PREDICT, 16'sd0));
    directed_rows.push_back(slot_row(S_MAX, 1, S_MAX, 1, EXP_PREDICT, 16'sd0));
    // Ratio above range acts as 1.0.
    directed_rows.push_back(reg_row(REG_PHONE_MIX_RATIO, 16'h7FFF));
    directed_rows.push_back(slot_row(S_MIN, 1, 16'sd0, 1, EXP_PREDICT, 16'sd0));
    // Mutes force the gains to zero.
    directed_rows.push_back(reg_row(REG_PHONE_MUTE, 16'h0001));
    directed_rows.push_back(slot_row(S_MAX, 1, 16'sd0, 0, EXP_TYPED, 16'sd0));
    directed_rows.push_back(reg_row(REG_MIC_MUTE, 16'h0001));
    directed_rows.push_back(slot_row(S_MIN, 1, S_MAX, 1, EXP_TYPED, 16'sd0));
    // A write to an index with no register behind it changes nothing.
    directed_rows.push_back(reg_row(REG_UNUSED_LAST, 16'hFFFF));
    directed_rows.push_back(slot_row(16'sd1, 1, -16'sd1, 1, EXP_TYPED, 16'sd0));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_REG) begin
        wait_mix_drained();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_data);
        finish_regs();
      end else begin
        send_slot(directed_rows[i].slot, directed_rows[i].exp_kind,
                  directed_rows[i].exp_sample);
      end
    end

    // Random phases, each under its own register setting.
    for (int phase = 0; phase < PHASES; phase++) begin
      int counted;
      mix_slot_t s;
      burst = (phase % 4 == 3);
      wait_mix_drained();
      program_setting(phase);
      finish_regs();
      counted = 0;
      while (counted < SLOTS_PER_PHASE) begin
        s = rand_slot();
        send_slot(s, EXP_PREDICT, 16'sd0);
        if (s.phone_valid || s.mic_valid) counted++;
        if ($urandom_range(0, 39) == 0) wait_mix_drained();
      end
    end
    burst = 1'b0;

    wait_mix_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mix_expected.size() != 0) begin
      err_count++;
      $display("%0t: %0d mixed_sample beats missing, expected %0d first, actual none",
               $time, mix_expected.size(), mix_expected[0]);
    end
    $display("Sent %0d slots (%0d with neither source present), checked %0d results.",
             slots_sent, empty_slots, results_checked);
    $display("Made %0d register writes across %0d settings plus the directed corners.",
             reg_writes, settings_used);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/mixsc_pkg.sv
hdl/mixsc_ifs.sv
hdl/two_source_gain_mixer_soft_clip.sv
tb/two_source_gain_mixer_soft_clip_tb.sv
